// ===== sv/swm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the star wildcard name matcher.
// Used by every module of the block; depends on nothing.
package swm_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] DOT_BYTE  = 8'd46;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_NAME    = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
        logic       last;
    } item_t;

endpackage

// ===== sv/star_wildcard_name_matcher_top.sv =====
`timescale 1ns / 1ps
// Top level of the star wildcard name matcher: input register, pattern store,
// position engine and result register. Depends on swm_pkg, swm_pattern and swm_engine.
//
// The block takes one item per clock cycle, pattern bytes and name bytes alike, unless the
// input stalls. A verdict passes the input register and then the result register. The rate
// is set by the update of the active-position vector, which includes the star closure as a
// logarithmic prefix network over all PATTERN_MAX positions. Pattern bytes beyond PATTERN_MAX
// are dropped and flag an overflow, and every verdict is then no match. A result that waits
// in the output register holds the next final name byte in the input register, and the
// input then stalls until the waiting result is taken.
module star_wildcard_name_matcher_top #(
    parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] char_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);

    swm_pkg::item_t s1_item_reg;
    logic           s1_valid_reg, s1_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic           matched_reg;
    logic           ovf_reg;

    logic                   produces;
    logic                   fire;
    logic                   load_en;
    logic                   name_en;
    logic [PATTERN_MAX-1:0] live;
    logic [PATTERN_MAX-1:0] star_live;
    logic [PATTERN_MAX-1:0] match_vec;
    logic [PATTERN_MAX:0]   start_vec;
    logic                   dot_lead;
    logic                   overflow;
    logic                   verdict;

    assign produces = (s1_item_reg.kind == swm_pkg::KIND_NAME) && s1_item_reg.last;
    assign fire     = s1_valid_reg && (!produces || !out_valid_reg || out_ready);
    assign load_en  = fire && (s1_item_reg.kind == swm_pkg::KIND_PATTERN);
    assign name_en  = fire && (s1_item_reg.kind == swm_pkg::KIND_NAME);
    assign in_ready = !s1_valid_reg || fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && produces)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.kind      <= kind;
            s1_item_reg.char_byte <= char_byte;
            s1_item_reg.last      <= last;
        end
        if (fire && produces)
        begin
            matched_reg <= verdict;
            ovf_reg     <= overflow;
        end
    end

    swm_pattern #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .item      (s1_item_reg),
        .live      (live),
        .star_live (star_live),
        .match_vec (match_vec),
        .start_vec (start_vec),
        .dot_lead  (dot_lead),
        .overflow  (overflow)
    );

    swm_engine #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .name_en   (name_en),
        .item      (s1_item_reg),
        .live      (live),
        .star_live (star_live),
        .match_vec (match_vec),
        .start_vec (start_vec),
        .dot_lead  (dot_lead),
        .overflow  (overflow),
        .matched   (verdict)
    );

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_reg;

    a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pattern_overflow |-> !matched)
        else $error("A verdict with pattern overflow reports a match.");

    a_result_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produces |=> out_valid)
        else $error("A final name byte was processed without a result.");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(fire && produces))
        else $error("A result appeared without a final name byte.");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && produces && out_valid_reg && !out_ready)
        else $error("Input stalled without a waiting result.");

endmodule

// ===== sv/swm_pattern.sv =====
`timescale 1ns / 1ps
// Pattern store: keeps the loaded pattern bytes, their star flags and a fill mask,
// and compares every stored byte against the current name byte. Depends on swm_pkg.
module swm_pattern #(
    parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_en,
    input  swm_pkg::item_t         item,
    output logic [PATTERN_MAX-1:0] live,
    output logic [PATTERN_MAX-1:0] star_live,
    output logic [PATTERN_MAX-1:0] match_vec,
    output logic [PATTERN_MAX:0]   start_vec,
    output logic                   dot_lead,
    output logic                   overflow
);

    logic [7:0]             store_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] star_reg;
    logic [PATTERN_MAX-1:0] live_reg, live_next;
    logic [PATTERN_MAX:0]   start_reg, start_next;
    logic                   all_star_reg, all_star_next;
    logic                   complete_reg, complete_next;
    logic                   ovf_reg, ovf_next;

    logic [PATTERN_MAX-1:0] live_eff;
    logic [PATTERN_MAX:0]   start_eff;
    logic                   all_star_eff;
    logic                   ovf_eff;
    logic [PATTERN_MAX:0]   tail_eff;
    logic [PATTERN_MAX:0]   live_shift;
    logic                   full;
    logic                   is_star;

    always_comb
    begin
        live_eff     = complete_reg ? '0 : live_reg;
        start_eff    = complete_reg ? {{PATTERN_MAX{1'b0}}, 1'b1} : start_reg;
        all_star_eff = complete_reg ? 1'b1 : all_star_reg;
        ovf_eff      = complete_reg ? 1'b0 : ovf_reg;
        live_shift   = {live_eff, 1'b1};
        tail_eff     = live_shift & ~{1'b0, live_eff};
        full         = live_eff[PATTERN_MAX-1];
        is_star      = (item.char_byte == swm_pkg::STAR_BYTE);

        live_next     = live_reg;
        start_next    = start_reg;
        all_star_next = all_star_reg;
        complete_next = complete_reg;
        ovf_next      = ovf_reg;
        if (load_en)
        begin
            complete_next = item.last;
            if (full)
            begin
                live_next     = live_eff;
                start_next    = start_eff;
                all_star_next = all_star_eff;
                ovf_next      = 1'b1;
            end
            else
            begin
                live_next     = live_shift[PATTERN_MAX-1:0];
                start_next    = start_eff
                                | ((all_star_eff && is_star) ? (tail_eff << 1) : '0);
                all_star_next = all_star_eff & is_star;
                ovf_next      = ovf_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            start_reg    <= {{PATTERN_MAX{1'b0}}, 1'b1};
            all_star_reg <= 1'b1;
            complete_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            live_reg     <= live_next;
            start_reg    <= start_next;
            all_star_reg <= all_star_next;
            complete_reg <= complete_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            if (load_en && !full && tail_eff[p])
            begin
                store_reg[p] <= item.char_byte;
                star_reg[p]  <= is_star;
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            match_vec[p] = (store_reg[p] == item.char_byte);
        end
    end

    assign live      = live_reg;
    assign star_live = star_reg & live_reg;
    assign start_vec = start_reg;
    assign dot_lead  = live_reg[0] && (store_reg[0] == swm_pkg::DOT_BYTE);
    assign overflow  = ovf_reg;

endmodule

// ===== sv/swm_engine.sv =====
`timescale 1ns / 1ps
// Active-position engine: advances the set of live pattern positions on each name
// byte, closes it over stars with a prefix network and forms the verdict. Depends on swm_pkg.
module swm_engine #(
    parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_en,
    input  logic                   name_en,
    input  swm_pkg::item_t         item,
    input  logic [PATTERN_MAX-1:0] live,
    input  logic [PATTERN_MAX-1:0] star_live,
    input  logic [PATTERN_MAX-1:0] match_vec,
    input  logic [PATTERN_MAX:0]   start_vec,
    input  logic                   dot_lead,
    input  logic                   overflow,
    output logic                   matched
);

    localparam int N      = PATTERN_MAX + 1;
    localparam int LEVELS = $clog2(N);

    logic [N-1:0] active_reg, active_next;
    logic         at_start_reg, at_start_next;
    logic         hidden_reg, hidden_next;

    logic [N-1:0]           base;
    logic [PATTERN_MAX-1:0] stay;
    logic [PATTERN_MAX-1:0] step;
    logic [N-1:0]           g_acc;
    logic [N-1:0]           p_acc;
    logic [N-1:0]           tail;
    logic                   hidden_now;

    always_comb
    begin
        base  = at_start_reg ? start_vec : active_reg;
        stay  = base[PATTERN_MAX-1:0] & star_live;
        step  = base[PATTERN_MAX-1:0] & live & ~star_live & match_vec;
        g_acc = {1'b0, stay} | {step, 1'b0};
        p_acc = {star_live, 1'b0};
        for (int k = 0; k < LEVELS; k++)
        begin
            g_acc = g_acc | (p_acc & (g_acc << (1 << k)));
            p_acc = p_acc & (p_acc << (1 << k));
        end
        tail       = {live, 1'b1} & ~{1'b0, live};
        hidden_now = at_start_reg
                     ? ((item.char_byte == swm_pkg::DOT_BYTE) && !dot_lead)
                     : hidden_reg;
        matched    = (|(g_acc & tail)) && !hidden_now && !overflow;

        active_next   = active_reg;
        at_start_next = at_start_reg;
        hidden_next   = hidden_reg;
        if (load_en || (name_en && item.last))
        begin
            active_next   = '0;
            at_start_next = 1'b1;
            hidden_next   = 1'b0;
        end
        else if (name_en)
        begin
            active_next   = g_acc;
            at_start_next = 1'b0;
            hidden_next   = hidden_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            at_start_reg <= 1'b1;
            hidden_reg   <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            at_start_reg <= at_start_next;
            hidden_reg   <= hidden_next;
        end
    end

endmodule
